[sv/cme_pkg.sv]
// ----------------------------------------------------------------------------
// cme_pkg
// Shared types, tables and the control program of the Codabar module encoder.
// ----------------------------------------------------------------------------
package cme_pkg;

  // Guard family fixed by the first character of a symbol
  typedef enum logic [1:0] {
    MODE_WAIT = 2'd0,  // awaiting first character, also "not a guard"
    MODE_ABCD = 2'd1,
    MODE_TNSE = 2'd2,
    MODE_DFLT = 2'd3   // default A guards added
  } guard_mode_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_GUARD = 2'd1,
    ERR_CHAR  = 2'd2
  } err_code_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } seq_state_t;

  // Micro-operations of one program step
  typedef enum logic [2:0] {
    OP_CHAR_A   = 3'd0,  // A guard pattern
    OP_CHAR_MID = 3'd1,  // latched middle character
    OP_CHAR_GRD = 3'd2,  // latched guard character
    OP_GAP      = 3'd3,  // one white module
    OP_ERR1     = 3'd4,  // guard error result
    OP_ERR2     = 3'd5,  // character error result
    OP_END      = 3'd6   // no result, return to dispatch
  } op_t;

  typedef struct packed {
    op_t  op;
    logic done;  // final step of the program: jump back to dispatch
  } ctrl_t;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  // Program entry points
  localparam pc_t PC_AMA  = 5'd0;   // A gap mid gap A
  localparam pc_t PC_GG   = 5'd5;   // guard gap
  localparam pc_t PC_AMG  = 5'd7;   // A gap mid gap
  localparam pc_t PC_MG   = 5'd11;  // mid gap
  localparam pc_t PC_MA   = 5'd13;  // mid gap A
  localparam pc_t PC_G    = 5'd16;  // guard
  localparam pc_t PC_ERR1 = 5'd17;
  localparam pc_t PC_ERR2 = 5'd18;
  localparam pc_t PC_NONE = 5'd19;

  localparam logic [4:0] IDX_GUARD_A = 5'd16;

  // Control store
  function automatic ctrl_t prog_rom(input pc_t pc);
    ctrl_t w;
    case (pc)
      5'd0:    w = '{OP_CHAR_A,   1'b0};
      5'd1:    w = '{OP_GAP,      1'b0};
      5'd2:    w = '{OP_CHAR_MID, 1'b0};
      5'd3:    w = '{OP_GAP,      1'b0};
      5'd4:    w = '{OP_CHAR_A,   1'b1};
      5'd5:    w = '{OP_CHAR_GRD, 1'b0};
      5'd6:    w = '{OP_GAP,      1'b1};
      5'd7:    w = '{OP_CHAR_A,   1'b0};
      5'd8:    w = '{OP_GAP,      1'b0};
      5'd9:    w = '{OP_CHAR_MID, 1'b0};
      5'd10:   w = '{OP_GAP,      1'b1};
      5'd11:   w = '{OP_CHAR_MID, 1'b0};
      5'd12:   w = '{OP_GAP,      1'b1};
      5'd13:   w = '{OP_CHAR_MID, 1'b0};
      5'd14:   w = '{OP_GAP,      1'b0};
      5'd15:   w = '{OP_CHAR_A,   1'b1};
      5'd16:   w = '{OP_CHAR_GRD, 1'b1};
      5'd17:   w = '{OP_ERR1,     1'b1};
      5'd18:   w = '{OP_ERR2,     1'b1};
      default: w = '{OP_END,      1'b1};
    endcase
    return w;
  endfunction

  // Wide/narrow element pattern, first element in bit 6
  function automatic logic [6:0] pattern(input logic [4:0] idx);
    logic [6:0] p;
    case (idx)
      5'd0:    p = 7'h03;
      5'd1:    p = 7'h06;
      5'd2:    p = 7'h09;
      5'd3:    p = 7'h60;
      5'd4:    p = 7'h12;
      5'd5:    p = 7'h42;
      5'd6:    p = 7'h21;
      5'd7:    p = 7'h24;
      5'd8:    p = 7'h30;
      5'd9:    p = 7'h48;
      5'd10:   p = 7'h0C;
      5'd11:   p = 7'h18;
      5'd12:   p = 7'h45;
      5'd13:   p = 7'h51;
      5'd14:   p = 7'h54;
      5'd15:   p = 7'h15;
      5'd16:   p = 7'h1A;
      5'd17:   p = 7'h29;
      5'd18:   p = 7'h0B;
      5'd19:   p = 7'h0E;
      default: p = 7'h03;
    endcase
    return p;
  endfunction

  // Middle character: {valid, index}
  function automatic logic [4:0] mid_index(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else begin
      case (c)
        8'h2D:   r = {1'b1, 4'd10};  // '-'
        8'h24:   r = {1'b1, 4'd11};  // '$'
        8'h3A:   r = {1'b1, 4'd12};  // ':'
        8'h2F:   r = {1'b1, 4'd13};  // '/'
        8'h2E:   r = {1'b1, 4'd14};  // '.'
        8'h2B:   r = {1'b1, 4'd15};  // '+'
        default: r = 5'd0;
      endcase
    end
    return r;
  endfunction

  // Guard family, MODE_WAIT for a non-guard
  function automatic guard_mode_t guard_family(input logic [7:0] c);
    guard_mode_t f;
    f = MODE_WAIT;
    if (c >= 8'h41 && c <= 8'h44) begin
      f = MODE_ABCD;
    end else if (c == 8'h54 || c == 8'h4E || c == 8'h2A || c == 8'h45) begin
      f = MODE_TNSE;
    end
    return f;
  endfunction

  // Guard pattern offset: A/T 0, B/N 1, C/* 2, else 3
  function automatic logic [1:0] guard_index(input logic [7:0] c);
    logic [1:0] g;
    case (c)
      8'h41, 8'h54: g = 2'd0;
      8'h42, 8'h4E: g = 2'd1;
      8'h43, 8'h2A: g = 2'd2;
      default:      g = 2'd3;
    endcase
    return g;
  endfunction

endpackage

[sv/codabar_module_encoder.sv]
// ----------------------------------------------------------------------------
// codabar_module_encoder
// Codabar encoder: characters in, one bar module (or error) per result out.
// ----------------------------------------------------------------------------
// Each accepted character runs a short program from a control store: one step
// per character pattern, gap or error, and one output module per clock while
// the output register is free. A character is dispatched, then its steps emit
// their results in order; an item that gives no result runs the empty step.
// The next character is taken once the program of the previous one has ended
// with its final result (if any) in the output register; stalls on the output
// side pause the sequencer.
module codabar_module_encoder
  import cme_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // final_char
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] module_bit, [7:1] zero
  output logic [2:0] out_tuser,  // [0] run_end, [2:1] error_code
  output logic       out_tlast   // symbol_end
);

  seq_state_t  state_r, state_nxt;
  pc_t         pc_r, pc_nxt;
  guard_mode_t mode_r, mode_nxt;
  logic        pend_r, pend_nxt;
  logic [3:0]  mid_idx_r, mid_idx_nxt;
  logic [1:0]  grd_idx_r, grd_idx_nxt;
  logic        fin_r, fin_nxt;
  logic [2:0]  elem_r, elem_nxt;
  logic        half_r, half_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_bit_r, out_bit_nxt;
  logic        out_run_r, out_run_nxt;
  logic        out_sym_r, out_sym_nxt;
  err_code_t   out_err_r, out_err_nxt;

  logic        in_acc;
  logic        adv;
  logic [4:0]  mid_dec;
  guard_mode_t fam;
  ctrl_t       ctrl;
  logic [4:0]  pat_idx;
  logic [6:0]  pat;
  logic        is_char;
  logic        wide;
  logic        step_end;
  pc_t         entry;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_bit_r};
  assign out_tuser  = {out_err_r, out_run_r};
  assign out_tlast  = out_sym_r;

  // Decode the incoming character
  assign mid_dec = mid_index(in_tdata);
  assign fam     = guard_family(in_tdata);

  // Current control word and character pattern
  assign ctrl = prog_rom(pc_r);
  always_comb begin
    case (ctrl.op)
      OP_CHAR_MID: pat_idx = {1'b0, mid_idx_r};
      OP_CHAR_GRD: pat_idx = {3'b100, grd_idx_r};
      default:     pat_idx = IDX_GUARD_A;
    endcase
  end
  assign pat     = pattern(pat_idx);
  assign is_char = (ctrl.op == OP_CHAR_A) || (ctrl.op == OP_CHAR_MID) ||
                   (ctrl.op == OP_CHAR_GRD);
  assign wide    = pat[3'd6 - elem_r];
  assign step_end = is_char ? ((elem_r == 3'd6) && (!wide || half_r)) : 1'b1;
  assign adv      = (state_r == ST_RUN) && (!out_valid_r || out_tready);

  // Dispatch: pick the program and update the symbol state
  always_comb begin
    entry    = PC_NONE;
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    if (mode_r == MODE_WAIT) begin
      if (in_tlast) begin
        entry = mid_dec[4] ? PC_AMA : PC_ERR2;
      end else if (fam != MODE_WAIT) begin
        entry    = PC_GG;
        mode_nxt = fam;
      end else begin
        mode_nxt = MODE_DFLT;
        if (mid_dec[4]) begin
          entry = PC_AMG;
        end else begin
          pend_nxt = 1'b1;
        end
      end
    end else if (!in_tlast) begin
      if (!pend_r) begin
        if (mid_dec[4]) begin
          entry = PC_MG;
        end else begin
          pend_nxt = 1'b1;
        end
      end
    end else if (mode_r == MODE_DFLT) begin
      if (fam != MODE_WAIT) begin
        entry = PC_ERR1;
      end else if (pend_r || !mid_dec[4]) begin
        entry = PC_ERR2;
      end else begin
        entry = PC_MA;
      end
    end else begin
      if (fam != mode_r) begin
        entry = PC_ERR1;
      end else if (pend_r) begin
        entry = PC_ERR2;
      end else begin
        entry = PC_G;
      end
    end
    // end of symbol: clear for the next one
    if (in_tlast) begin
      mode_nxt = MODE_WAIT;
      pend_nxt = 1'b0;
    end
  end

  // Sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    mid_idx_nxt   = mid_idx_r;
    grd_idx_nxt   = grd_idx_r;
    fin_nxt       = fin_r;
    elem_nxt      = elem_r;
    half_nxt      = half_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_bit_nxt   = out_bit_r;
    out_run_nxt   = out_run_r;
    out_sym_nxt   = out_sym_r;
    out_err_nxt   = out_err_r;
    if (in_acc) begin
      state_nxt   = ST_RUN;
      pc_nxt      = entry;
      mid_idx_nxt = mid_dec[3:0];
      grd_idx_nxt = guard_index(in_tdata);
      fin_nxt     = in_tlast;
      elem_nxt    = 3'd0;
      half_nxt    = 1'b0;
    end else if (adv) begin
      // emit one result unless the step carries none
      if (ctrl.op != OP_END) begin
        out_valid_nxt = 1'b1;
        out_bit_nxt   = is_char && !elem_r[0];
        out_run_nxt   = ctrl.done && step_end;
        out_sym_nxt   = ctrl.done && step_end && fin_r;
        case (ctrl.op)
          OP_ERR1: out_err_nxt = ERR_GUARD;
          OP_ERR2: out_err_nxt = ERR_CHAR;
          default: out_err_nxt = ERR_NONE;
        endcase
      end
      // advance the element, the step or return to dispatch
      if (step_end) begin
        elem_nxt = 3'd0;
        half_nxt = 1'b0;
        if (ctrl.done) begin
          state_nxt = ST_IDLE;
        end else begin
          pc_nxt = pc_r + 5'd1;
        end
      end else if (wide && !half_r) begin
        half_nxt = 1'b1;
      end else begin
        half_nxt = 1'b0;
        elem_nxt = elem_r + 3'd1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_WAIT;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= PC_NONE;
      elem_r      <= 3'd0;
      half_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pc_r        <= pc_nxt;
      elem_r      <= elem_nxt;
      half_r      <= half_nxt;
      if (in_acc) begin
        mode_r <= mode_nxt;
        pend_r <= pend_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mid_idx_r <= mid_idx_nxt;
    grd_idx_r <= grd_idx_nxt;
    fin_r     <= fin_nxt;
    out_bit_r <= out_bit_nxt;
    out_run_r <= out_run_nxt;
    out_sym_r <= out_sym_nxt;
    out_err_r <= out_err_nxt;
  end

  // Checks
  a_err_result_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r != ERR_NONE) |-> (!out_bit_r && out_run_r && out_sym_r))
    else $error("error result must be a white, final result");

  a_sym_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sym_r) |-> out_run_r)
    else $error("symbol end without run end");

  a_symbol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (mode_r == MODE_WAIT && !pend_r))
    else $error("guard state not cleared after last character");

  a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (elem_r <= 3'd6))
    else $error("element counter out of range");

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Codabar module encoder.
// ----------------------------------------------------------------------------
// Characters are streamed in from a queue of pending requests, and a local
// copy of the encoder's guard and error state predicts every bar module and
// error result. A short directed part covers each guard family, default
// guards, lone characters and the error rules. A random part follows, mostly
// well-formed symbols with some broken ones and noise. Both sides idle at
// random. The receiver holds off once for a long stretch, and the sender
// waits once for the encoder to drain.
// ----------------------------------------------------------------------------
module testbench
  import cme_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] code;
    bit         last;
    bit         drain_first;  // hold this request until all results are in
  } char_req_t;

  typedef struct {
    bit        bar;
    bit        run_end;
    bit        sym_end;
    err_code_t err;
  } bar_result_t;

  // Element patterns, first element in bit 6: digits, -$:/.+, then A-D guards
  localparam logic [6:0] BAR_PATTERN [20] = '{
    7'h03, 7'h06, 7'h09, 7'h60, 7'h12, 7'h42, 7'h21, 7'h24, 7'h30, 7'h48,
    7'h0C, 7'h18, 7'h45, 7'h51, 7'h54, 7'h15, 7'h1A, 7'h29, 7'h0B, 7'h0E
  };
  localparam int SLOT_GUARD_A = 16;
  localparam int TAIL_CYCLES  = 40;

  string mid_set  = "0123456789-$:/.+";
  string abcd_set = "ABCD";
  string tnse_set = "TN*E";

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'd0;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;

  char_req_t   pending_chars[$];
  bar_result_t modules_due[$];
  bar_result_t char_run[$];

  guard_mode_t sym_mode     = MODE_WAIT;
  bit          sym_char_err = 1'b0;

  int errors      = 0;
  int n_sent      = 0;
  int n_queued    = 0;
  int rx_cycles   = 0;
  int stall_left  = 0;
  bit stall_done  = 1'b0;
  bit drain_asked = 1'b0;

  codabar_module_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Encoder prediction
  // --------------------------------------------------------------------------

  // Pattern slot of an encodable middle character, -1 otherwise
  function automatic int mid_slot(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    case (c)
      "-":     return 10;
      "$":     return 11;
      ":":     return 12;
      "/":     return 13;
      ".":     return 14;
      "+":     return 15;
      default: return -1;
    endcase
  endfunction

  function automatic guard_mode_t guard_kind(logic [7:0] c);
    if (c >= "A" && c <= "D") return MODE_ABCD;
    if (c == "T" || c == "N" || c == "*" || c == "E") return MODE_TNSE;
    return MODE_WAIT;
  endfunction

  // TN*E guards are drawn with the A-D patterns
  function automatic int guard_slot(logic [7:0] c);
    case (c)
      "A", "T": return 16;
      "B", "N": return 17;
      "C", "*": return 18;
      default:  return 19;
    endcase
  endfunction

  function automatic void add_module(bit bar, err_code_t err);
    bar_result_t r;
    r.bar     = bar;
    r.run_end = 1'b0;
    r.sym_end = 1'b0;
    r.err     = err;
    char_run.push_back(r);
  endfunction

  // Seven elements, alternating black and white, wide ones two modules
  function automatic void add_char(int slot);
    bit black;
    black = 1'b1;
    for (int e = 0; e < 7; e++) begin
      add_module(black, ERR_NONE);
      if (BAR_PATTERN[slot][6-e]) add_module(black, ERR_NONE);
      black = ~black;
    end
  endfunction

  function automatic void encode_char(logic [7:0] c, bit fin);
    int          mid;
    guard_mode_t fam;
    err_code_t   err;
    mid = mid_slot(c);
    fam = guard_kind(c);
    err = ERR_NONE;
    char_run.delete();
    if (sym_mode == MODE_WAIT) begin
      if (fin) begin
        // lone character between two added A guards
        if (mid >= 0) begin
          add_char(SLOT_GUARD_A);
          add_module(1'b0, ERR_NONE);
          add_char(mid);
          add_module(1'b0, ERR_NONE);
          add_char(SLOT_GUARD_A);
        end else begin
          err = ERR_CHAR;
        end
      end else if (fam != MODE_WAIT) begin
        sym_mode = fam;
        add_char(guard_slot(c));
        add_module(1'b0, ERR_NONE);
      end else begin
        sym_mode = MODE_DFLT;
        if (mid >= 0) begin
          add_char(SLOT_GUARD_A);
          add_module(1'b0, ERR_NONE);
          add_char(mid);
          add_module(1'b0, ERR_NONE);
        end else begin
          sym_char_err = 1'b1;
        end
      end
    end else if (!fin) begin
      // drop everything after an unencodable character
      if (!sym_char_err) begin
        if (mid >= 0) begin
          add_char(mid);
          add_module(1'b0, ERR_NONE);
        end else begin
          sym_char_err = 1'b1;
        end
      end
    end else if (sym_mode == MODE_DFLT) begin
      if (fam != MODE_WAIT) begin
        err = ERR_GUARD;
      end else if (sym_char_err || mid < 0) begin
        err = ERR_CHAR;
      end else begin
        add_char(mid);
        add_module(1'b0, ERR_NONE);
        add_char(SLOT_GUARD_A);
      end
    end else begin
      if (fam != sym_mode) err = ERR_GUARD;
      else if (sym_char_err) err = ERR_CHAR;
      else add_char(guard_slot(c));
    end

    if (fin) begin
      if (err != ERR_NONE) begin
        char_run.delete();
        add_module(1'b0, err);
      end
      sym_mode     = MODE_WAIT;
      sym_char_err = 1'b0;
    end
    if (char_run.size() > 0) begin
      char_run[char_run.size()-1].run_end = 1'b1;
      char_run[char_run.size()-1].sym_end = fin;
    end
    foreach (char_run[i]) modules_due.push_back(char_run[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  function automatic void add_req(logic [7:0] code, bit last);
    char_req_t q;
    q.code        = code;
    q.last        = last;
    q.drain_first = 1'b0;
    // one pause for a full drain, at the start of a symbol midway through
    if (!drain_asked && n_queued >= 120 && (pending_chars.size() == 0 ||
        pending_chars[pending_chars.size()-1].last)) begin
      q.drain_first = 1'b1;
      drain_asked   = 1'b1;
    end
    pending_chars.push_back(q);
    n_queued++;
  endfunction

  function automatic logic [7:0] pick_mid();
    return mid_set[$urandom_range(15)];
  endfunction

  function automatic logic [7:0] pick_guard(bit tnse);
    return tnse ? tnse_set[$urandom_range(3)] : abcd_set[$urandom_range(3)];
  endfunction

  function automatic void add_random_symbol();
    int  kind;
    int  len;
    int  bad_at;
    bit  tnse;
    kind = $urandom_range(99);
    tnse = 1'($urandom_range(1));
    if (kind < 45) begin
      // guarded and well formed
      len = $urandom_range(6);
      add_req(pick_guard(tnse), 1'b0);
      for (int i = 0; i < len; i++) add_req(pick_mid(), 1'b0);
      add_req(pick_guard(tnse), 1'b1);
    end else if (kind < 70) begin
      // default guards
      len = $urandom_range(6, 1);
      for (int i = 0; i < len; i++) add_req(pick_mid(), i == len - 1);
    end else if (kind < 80) begin
      // lone character
      add_req($urandom_range(1) ? pick_mid() : 8'($urandom_range(255)), 1'b1);
    end else if (kind < 90) begin
      // broken: a stray byte inside, end guard of either family
      len    = $urandom_range(5, 1);
      bad_at = $urandom_range(len - 1);
      add_req(pick_guard(tnse), 1'b0);
      for (int i = 0; i < len; i++) begin
        add_req(i == bad_at ? 8'($urandom_range(255)) : pick_mid(), 1'b0);
      end
      add_req(pick_guard(1'($urandom_range(1))), 1'b1);
    end else begin
      // noise
      len = $urandom_range(5, 1);
      for (int i = 0; i < len; i++) add_req(8'($urandom_range(255)), i == len - 1);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'd0;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        encode_char(in_tdata, in_tlast);
        n_sent++;
      end
      // hold an offered request until it is taken
      if (!in_tvalid || in_tready) begin
        if (pending_chars.size() > 0 &&
            (!pending_chars[0].drain_first || modules_due.size() == 0) &&
            ((n_sent >= 150 && n_sent < 210) || $urandom_range(99) >= 29)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_chars[0].code;
          in_tlast  <= pending_chars[0].last;
          pending_chars.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycles++;
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!stall_done && n_sent >= 40) begin
        // long hold-off so the encoder backs up into its input
        stall_left = 300;
        stall_done = 1'b1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= (rx_cycles >= 2000 && rx_cycles < 3000) ||
                      $urandom_range(99) >= 29;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bar_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (modules_due.size() == 0) begin
        $display("%0t: unexpected result, tdata=%h tuser=%h tlast=%b",
                 $time, out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        want = modules_due.pop_front();
        if (out_tdata !== {7'd0, want.bar}) begin
          $display("%0t: module_bit expected %h got %h", $time, {7'd0, want.bar},
                   out_tdata);
          errors++;
        end
        if (out_tuser[0] !== want.run_end) begin
          $display("%0t: run_end expected %b got %b", $time, want.run_end,
                   out_tuser[0]);
          errors++;
        end
        if (out_tlast !== want.sym_end) begin
          $display("%0t: symbol_end expected %b got %b", $time, want.sym_end,
                   out_tlast);
          errors++;
        end
        if (out_tuser[2:1] !== want.err) begin
          $display("%0t: error_code expected %0d got %0d", $time, want.err,
                   out_tuser[2:1]);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: directed symbols, random symbols, reset, drain and verdict
  // --------------------------------------------------------------------------
  initial begin
    // lone digit, lone guard letter, lone top byte
    add_req("7", 1'b1);
    add_req("B", 1'b1);
    add_req(8'hFF, 1'b1);
    // TN*E guards around middle characters
    add_req("T", 1'b0);
    add_req("0", 1'b0);
    add_req("-", 1'b0);
    add_req("E", 1'b1);
    // mismatched guard families
    add_req("A", 1'b0);
    add_req("1", 1'b0);
    add_req("N", 1'b1);
    // unencodable middle character, then nothing until the error
    add_req("A", 1'b0);
    add_req("x", 1'b0);
    add_req("2", 1'b0);
    add_req("B", 1'b1);
    // default guards
    add_req("3", 1'b0);
    add_req(".", 1'b0);
    add_req("+", 1'b1);
    // default guards closed by a guard letter
    add_req("4", 1'b0);
    add_req("C", 1'b1);
    // guard error wins over a pending character error
    add_req(8'h00, 1'b0);
    add_req("5", 1'b0);
    add_req("*", 1'b1);
    // pending character error closed by a digit
    add_req("9", 1'b0);
    add_req(8'h80, 1'b0);
    add_req("1", 1'b1);

    while (n_queued < 260) add_random_symbol();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_chars.size() > 0 || in_tvalid) @(negedge clk);
    while (modules_due.size() > 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (modules_due.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, modules_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
